/* hdl/ttpl_pkg.sv */
// ----------------------------------------------------------------------------
// ttpl_pkg - shared types and constants
// Widths, stage counts and payload structs of the tube track path length block.
// ----------------------------------------------------------------------------
package ttpl_pkg;

	localparam int COORD_W      = 32;
	localparam int SLOPE_W      = 18;
	localparam int RADIUS_W     = 20;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 20'd19857;

	// |N| fits 51 bits, a^2 + dz^2 (+ b^2) fits 36 bits
	localparam int AN_W         = 51;
	localparam int Q_W          = 36;

	// widths and stage counts of the arithmetic units
	localparam int DVD_W        = 60;
	localparam int DVS_W        = 36;
	localparam int RAD_W        = 60;
	localparam int ROOT_W       = RAD_W / 2;
	localparam int SQRT_STAGES  = ROOT_W;
	localparam int DIV_STAGES   = DVD_W;

	localparam int DIST_W       = 32;
	localparam int LEN_W        = 32;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic signed [SLOPE_W-1:0] slope_dx;
		logic signed [SLOPE_W-1:0] slope_dy;
		logic signed [SLOPE_W-1:0] slope_dz;
		logic                      tube_axis;
		logic signed [COORD_W-1:0] tube_z;
		logic signed [COORD_W-1:0] tube_coord;
	} item_t;

	typedef struct packed {
		logic            err;
		logic [AN_W-1:0] an;
		logic [Q_W-1:0]  q;
		logic [Q_W-1:0]  q3;
	} front_t;

endpackage

/* hdl/ttpl_ifs.sv */
// ----------------------------------------------------------------------------
// ttpl_ifs - channel interfaces
// Track input, result output and radius write channels with valid/ready.
// ----------------------------------------------------------------------------
interface ttpl_item_if;
	import ttpl_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic signed [COORD_W-1:0] point_z;
	logic signed [SLOPE_W-1:0] slope_dx;
	logic signed [SLOPE_W-1:0] slope_dy;
	logic signed [SLOPE_W-1:0] slope_dz;
	logic                      tube_axis;
	logic signed [COORD_W-1:0] tube_z;
	logic signed [COORD_W-1:0] tube_coord;

	modport source (output valid, point_x, point_y, point_z, slope_dx, slope_dy,
		slope_dz, tube_axis, tube_z, tube_coord, input ready);
	modport sink (input valid, point_x, point_y, point_z, slope_dx, slope_dy,
		slope_dz, tube_axis, tube_z, tube_coord, output ready);
endinterface

interface ttpl_result_if;
	import ttpl_pkg::*;

	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] axis_distance;
	logic [LEN_W-1:0]  path_length;
	logic              crosses_tube;
	logic              slope_error;

	modport source (output valid, axis_distance, path_length, crosses_tube,
		slope_error, input ready);
	modport sink (input valid, axis_distance, path_length, crosses_tube,
		slope_error, output ready);
endinterface

interface ttpl_cfg_if;
	import ttpl_pkg::*;

	logic                valid;
	logic                ready;
	logic [RADIUS_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* hdl/tube_track_path_length.sv */
// Stages from track transfer to result: 3 front end, 30 root, 60 divide,
// 2 chord, 30 root, 2 length and output register.
// Throughput: one track per cycle; every stage holds while a result waits.
// Reset clears all valid bits and loads the tube radius with 0.303 cm.
// ----------------------------------------------------------------------------
// tube_track_path_length - track to tube distance and path length
// Distance in the measuring plane and 3D chord length through the tube.
// ----------------------------------------------------------------------------
module tube_track_path_length (
	input  logic          clk,
	input  logic          arst_n,
	ttpl_item_if.sink     track,
	ttpl_result_if.source result,
	ttpl_cfg_if.sink      cfg
);
	import ttpl_pkg::*;

	localparam int GDLY   = SQRT_STAGES + 2;
	localparam int RSQ_W  = 2 * RADIUS_W;
	localparam int PROD_W = 2 * ROOT_W;
	localparam int LSH    = 19;
	localparam int DC_W   = DIST_W + 2;

	logic                en;
	logic [RADIUS_W-1:0] radius_q;
	item_t               item;

	logic                front_vld;
	front_t              front;

	logic                sa_vld;
	logic [ROOT_W-1:0]   sa_root;
	logic                dd_vld;
	logic [DVD_W-1:0]    dd_quo;
	logic                dg_vld;
	logic [DVD_W-1:0]    dg_quo;
	logic                sg_vld;
	logic [ROOT_W-1:0]   sg_root;
	logic                sw_vld;
	logic [ROOT_W-1:0]   sw_root;

	logic [AN_W:0]       an_dl_q  [SQRT_STAGES];
	logic                err_dl_q [DIV_STAGES];
	logic [DC_W-1:0]     dc_dl_q  [SQRT_STAGES];
	logic                g_vld_dl_q [GDLY];
	logic [ROOT_W-1:0]   g_dl_q   [GDLY];

	logic [DIST_W-1:0]   dist_c;
	logic                vld_s1, vld_s2, vld_s3, vld_s4;
	logic                err_s1, err_s2, err_s3, err_s4;
	logic                cross_s1, cross_s2, cross_s3, cross_s4;
	logic [DIST_W-1:0]   dist_s1, dist_s2, dist_s3, dist_s4;
	logic [RSQ_W-1:0]    dsq_s1, rsq_s1, m_s2;
	logic [PROD_W-1:0]   prod_s3;
	logic [LEN_W-1:0]    len_s4;
	logic [PROD_W-LSH-1:0] len_c;

	// hold the whole pipeline while a result waits
	assign en          = !vld_s4 || result.ready;
	assign track.ready = en;
	assign cfg.ready   = 1'b1;

	// radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg.valid) begin
			radius_q <= cfg.data;
		end
	end

	assign item.point_x    = track.point_x;
	assign item.point_y    = track.point_y;
	assign item.point_z    = track.point_z;
	assign item.slope_dx   = track.slope_dx;
	assign item.slope_dy   = track.slope_dy;
	assign item.slope_dz   = track.slope_dz;
	assign item.tube_axis  = track.tube_axis;
	assign item.tube_z     = track.tube_z;
	assign item.tube_coord = track.tube_coord;

	ttpl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (track.valid && track.ready),
		.item   (item),
		.out_vld(front_vld),
		.out    (front)
	);

	// s = isqrt(Q * 2^16)
	ttpl_isqrt u_sqrt_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (front_vld),
		.in_rad  ({(RAD_W-Q_W-16)'(0), front.q, 16'b0}),
		.out_vld (sa_vld),
		.out_root(sa_root)
	);

	// Q3 * 2^24 / Q
	ttpl_div u_div_ratio (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (front_vld),
		.dvd    ({front.q3, 24'b0}),
		.dvs    (front.q),
		.out_vld(dg_vld),
		.quo    (dg_quo)
	);

	// g = isqrt of the ratio
	ttpl_isqrt u_sqrt_ratio (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (dg_vld),
		.in_rad  (dg_quo),
		.out_vld (sg_vld),
		.out_root(sg_root)
	);

	// delay |N| and the error flag alongside the norm root
	always_ff @(posedge clk) begin
		if (en) begin
			an_dl_q[0] <= {front.err, front.an};
			for (int k = 1; k < SQRT_STAGES; k++) begin
				an_dl_q[k] <= an_dl_q[k-1];
			end
		end
	end

	// distance = |N| * 2^8 / s
	ttpl_div u_div_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_vld (sa_vld),
		.dvd    ({(DVD_W-AN_W-8)'(0), an_dl_q[SQRT_STAGES-1][AN_W-1:0], 8'b0}),
		.dvs    ({(DVS_W-ROOT_W)'(0), sa_root}),
		.out_vld(dd_vld),
		.quo    (dd_quo)
	);

	// delay the error flag alongside the distance divider
	always_ff @(posedge clk) begin
		if (en) begin
			err_dl_q[0] <= an_dl_q[SQRT_STAGES-1][AN_W];
			for (int k = 1; k < DIV_STAGES; k++) begin
				err_dl_q[k] <= err_dl_q[k-1];
			end
		end
	end

	// saturate the distance, zero it on a flat track
	always_comb begin
		if (err_dl_q[DIV_STAGES-1]) begin
			dist_c = '0;
		end else if (|dd_quo[DVD_W-1:DIST_W]) begin
			dist_c = '1;
		end else begin
			dist_c = dd_quo[DIST_W-1:0];
		end
	end

	// chord stages valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= dd_vld;
			vld_s2 <= vld_s1;
		end
	end

	// squares of distance and radius, then R^2 - d^2 when crossing
	always_ff @(posedge clk) begin
		if (en) begin
			err_s1   <= err_dl_q[DIV_STAGES-1];
			dist_s1  <= dist_c;
			cross_s1 <= !err_dl_q[DIV_STAGES-1] && (dist_c < DIST_W'(radius_q));
			dsq_s1   <= RSQ_W'(dist_c) * RSQ_W'(dist_c);
			rsq_s1   <= RSQ_W'(radius_q) * RSQ_W'(radius_q);

			err_s2   <= err_s1;
			dist_s2  <= dist_s1;
			cross_s2 <= cross_s1;
			m_s2     <= cross_s1 ? (rsq_s1 - dsq_s1) : '0;
		end
	end

	// w = isqrt(m * 2^16)
	ttpl_isqrt u_sqrt_chord (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s2),
		.in_rad  ({(RAD_W-RSQ_W-16)'(0), m_s2, 16'b0}),
		.out_vld (sw_vld),
		.out_root(sw_root)
	);

	// delay distance, crossing and error alongside the chord root
	always_ff @(posedge clk) begin
		if (en) begin
			dc_dl_q[0] <= {err_s2, cross_s2, dist_s2};
			for (int k = 1; k < SQRT_STAGES; k++) begin
				dc_dl_q[k] <= dc_dl_q[k-1];
			end
		end
	end

	// delay g by the chord stages and the chord root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < GDLY; k++) begin
				g_vld_dl_q[k] <= 1'b0;
			end
		end else if (en) begin
			g_vld_dl_q[0] <= sg_vld;
			for (int k = 1; k < GDLY; k++) begin
				g_vld_dl_q[k] <= g_vld_dl_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_dl_q[0] <= sg_root;
			for (int k = 1; k < GDLY; k++) begin
				g_dl_q[k] <= g_dl_q[k-1];
			end
		end
	end

	// length and output stages valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s3 <= sw_vld && g_vld_dl_q[GDLY-1];
			vld_s4 <= vld_s3;
		end
	end

	// 2 * w * g / 2^20, saturated
	assign len_c = prod_s3[PROD_W-1:LSH];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3  <= PROD_W'(sw_root) * PROD_W'(g_dl_q[GDLY-1]);
			err_s3   <= dc_dl_q[SQRT_STAGES-1][DC_W-1];
			cross_s3 <= dc_dl_q[SQRT_STAGES-1][DC_W-2];
			dist_s3  <= dc_dl_q[SQRT_STAGES-1][DIST_W-1:0];

			err_s4   <= err_s3;
			cross_s4 <= cross_s3;
			dist_s4  <= dist_s3;
			if (!cross_s3) begin
				len_s4 <= '0;
			end else if (|len_c[PROD_W-LSH-1:LEN_W]) begin
				len_s4 <= '1;
			end else begin
				len_s4 <= len_c[LEN_W-1:0];
			end
		end
	end

	assign result.valid         = vld_s4;
	assign result.axis_distance = dist_s4;
	assign result.path_length   = len_s4;
	assign result.crosses_tube  = cross_s4;
	assign result.slope_error   = err_s4;

endmodule

/* hdl/ttpl_front.sv */
// ----------------------------------------------------------------------------
// ttpl_front - geometry front end
// Three stages: differences, products and squares, then |N|, Q and Q3.
// ----------------------------------------------------------------------------
module ttpl_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  ttpl_pkg::item_t  item,
	output logic             out_vld,
	output ttpl_pkg::front_t out
);
	import ttpl_pkg::*;

	localparam int DIFF_W = COORD_W + 1;
	localparam int PROD_W = DIFF_W + SLOPE_W;
	localparam int SQ_W   = 2 * SLOPE_W;

	logic                      vld_s1, vld_s2, vld_s3;
	logic                      err_s1, err_s2, err_s3;
	logic signed [SLOPE_W-1:0] a_s1, b_s1, dz_s1;
	logic signed [DIFF_W-1:0]  cd_s1, zd_s1;
	logic signed [PROD_W-1:0]  pa_s2, pb_s2;
	logic [SQ_W-2:0]           a2_s2, b2_s2, dz2_s2;
	logic [AN_W-1:0]           an_s3;
	logic [Q_W-1:0]            q_s3, q3_s3;

	logic signed [SLOPE_W-1:0] a_c, b_c;
	logic signed [COORD_W-1:0] c_c;
	logic signed [SQ_W-1:0]    a2_c, b2_c, dz2_c;
	logic signed [PROD_W:0]    n_c;
	logic [Q_W-1:0]            q_c;

	// pick measured and other transverse components
	always_comb begin
		if (item.tube_axis) begin
			a_c = item.slope_dy;
			b_c = item.slope_dx;
			c_c = item.point_y;
		end else begin
			a_c = item.slope_dx;
			b_c = item.slope_dy;
			c_c = item.point_x;
		end
	end

	// squares of the direction components
	always_comb begin
		a2_c  = SQ_W'(a_s1) * SQ_W'(a_s1);
		b2_c  = SQ_W'(b_s1) * SQ_W'(b_s1);
		dz2_c = SQ_W'(dz_s1) * SQ_W'(dz_s1);
	end

	// combine numerator and norms
	always_comb begin
		n_c = (PROD_W+1)'(pa_s2) + (PROD_W+1)'(pb_s2);
		q_c = Q_W'(a2_s2) + Q_W'(dz2_s2);
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			err_s1 <= (item.slope_dz == '0);
			a_s1   <= a_c;
			b_s1   <= b_c;
			dz_s1  <= item.slope_dz;
			cd_s1  <= DIFF_W'(c_c) - DIFF_W'(item.tube_coord);
			zd_s1  <= DIFF_W'(item.tube_z) - DIFF_W'(item.point_z);

			err_s2 <= err_s1;
			pa_s2  <= PROD_W'(cd_s1) * PROD_W'(dz_s1);
			pb_s2  <= PROD_W'(a_s1) * PROD_W'(zd_s1);
			a2_s2  <= a2_c[SQ_W-2:0];
			b2_s2  <= b2_c[SQ_W-2:0];
			dz2_s2 <= dz2_c[SQ_W-2:0];

			err_s3 <= err_s2;
			an_s3  <= n_c[PROD_W] ? AN_W'(-n_c) : AN_W'(n_c);
			q_s3   <= q_c;
			q3_s3  <= q_c + Q_W'(b2_s2);
		end
	end

	assign out_vld = vld_s3;
	assign out.err = err_s3;
	assign out.an  = an_s3;
	assign out.q   = q_s3;
	assign out.q3  = q3_s3;

endmodule

/* hdl/ttpl_isqrt.sv */
// ----------------------------------------------------------------------------
// ttpl_isqrt - pipelined integer square root
// One result bit per stage, truncating root of a 60-bit radicand.
// ----------------------------------------------------------------------------
module ttpl_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [ttpl_pkg::RAD_W-1:0]  in_rad,
	output logic                        out_vld,
	output logic [ttpl_pkg::ROOT_W-1:0] out_root
);
	import ttpl_pkg::*;

	localparam int REM_W = ROOT_W + 2;

	logic              vld_s  [SQRT_STAGES];
	logic [RAD_W-1:0]  rad_s  [SQRT_STAGES];
	logic [REM_W-1:0]  rem_s  [SQRT_STAGES];
	logic [ROOT_W-1:0] root_s [SQRT_STAGES];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_step
		logic              vld_in;
		logic [RAD_W-1:0]  rad_in;
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [REM_W+1:0]  acc;
		logic [REM_W+1:0]  trial;

		if (k == 0) begin : g_first
			assign vld_in  = in_vld;
			assign rad_in  = in_rad;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
		end

		// bring down two radicand bits and form the trial value
		always_comb begin
			acc   = {rem_in, rad_in[RAD_W-1 -: 2]};
			trial = {2'b00, root_in, 2'b01};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		// subtract when the trial fits, shift in the root bit
		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k] <= rad_in << 2;
				if (acc >= trial) begin
					rem_s[k]  <= REM_W'(acc - trial);
					root_s[k] <= {root_in[ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[k]  <= REM_W'(acc);
					root_s[k] <= {root_in[ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_vld  = vld_s[SQRT_STAGES-1];
	assign out_root = root_s[SQRT_STAGES-1];

endmodule

/* hdl/ttpl_div.sv */
// ----------------------------------------------------------------------------
// ttpl_div - pipelined restoring divider
// One quotient bit per stage, truncating 60-bit by 36-bit division.
// ----------------------------------------------------------------------------
module ttpl_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  logic [ttpl_pkg::DVD_W-1:0] dvd,
	input  logic [ttpl_pkg::DVS_W-1:0] dvs,
	output logic                       out_vld,
	output logic [ttpl_pkg::DVD_W-1:0] quo
);
	import ttpl_pkg::*;

	logic             vld_s [DIV_STAGES];
	logic [DVD_W-1:0] dvd_s [DIV_STAGES];
	logic [DVS_W-1:0] dvs_s [DIV_STAGES];
	logic [DVS_W-1:0] rem_s [DIV_STAGES];
	logic [DVD_W-1:0] quo_s [DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
		logic             vld_in;
		logic [DVD_W-1:0] dvd_in;
		logic [DVS_W-1:0] dvs_in;
		logic [DVS_W-1:0] rem_in;
		logic [DVD_W-1:0] quo_in;
		logic [DVS_W:0]   acc;

		if (k == 0) begin : g_first
			assign vld_in = in_vld;
			assign dvd_in = dvd;
			assign dvs_in = dvs;
			assign rem_in = '0;
			assign quo_in = '0;
		end else begin : g_next
			assign vld_in = vld_s[k-1];
			assign dvd_in = dvd_s[k-1];
			assign dvs_in = dvs_s[k-1];
			assign rem_in = rem_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		// bring down the next dividend bit
		assign acc = {rem_in, dvd_in[DVD_W-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		// subtract when the divisor fits, shift in the quotient bit
		always_ff @(posedge clk) begin
			if (en) begin
				dvd_s[k] <= dvd_in << 1;
				dvs_s[k] <= dvs_in;
				if (acc >= {1'b0, dvs_in}) begin
					rem_s[k] <= DVS_W'(acc - {1'b0, dvs_in});
					quo_s[k] <= {quo_in[DVD_W-2:0], 1'b1};
				end else begin
					rem_s[k] <= DVS_W'(acc);
					quo_s[k] <= {quo_in[DVD_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_vld = vld_s[DIV_STAGES-1];
	assign quo     = quo_s[DIV_STAGES-1];

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - tube track path length block
// Drives tracks against tubes through the valid/ready channels, predicts the
// axis distance and the chord length in fixed point, and checks every result
// in order. Covers radius settings, zero dz, both tube axes, field extremes
// and back pressure.
// ----------------------------------------------------------------------------
module testbench;
	import ttpl_pkg::*;

	typedef struct packed {
		logic [DIST_W-1:0] axis_distance;
		logic [LEN_W-1:0]  path_length;
		logic              crosses_tube;
		logic              slope_error;
	} chord_t;

	localparam int LATENCY     = 127;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_LEN    = 600;

	logic clk;
	logic arst_n;

	ttpl_item_if   track_ch();
	ttpl_result_if result_ch();
	ttpl_cfg_if    cfg_ch();

	tube_track_path_length u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.track  (track_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	logic [RADIUS_W-1:0] radius_now;
	chord_t              chord_q[$];
	int                  n_fail;
	bit                  hold_req;
	int                  quiet_cycles;

	// integer square root, truncating
	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r;
		longint unsigned bt;
		r  = 0;
		bt = 64'd1 << 62;
		while (bt > v)
			bt = bt >> 2;
		while (bt != 0) begin
			if (v >= r + bt) begin
				v = v - (r + bt);
				r = (r >> 1) + bt;
			end else begin
				r = r >> 1;
			end
			bt = bt >> 2;
		end
		return r;
	endfunction

	// distance to the tube axis and chord length through the tube
	function automatic chord_t chord_of(input item_t it, input logic [RADIUS_W-1:0] rad);
		chord_t          res;
		longint          a, b, c, n, dz;
		longint unsigned an, q, q3, s, axis_d, m, w, g, len, rr;
		res = '0;
		dz  = longint'(it.slope_dz);
		if (dz == 0) begin
			res.slope_error = 1'b1;
			return res;
		end
		if (!it.tube_axis) begin
			a = it.slope_dx; b = it.slope_dy; c = it.point_x;
		end else begin
			a = it.slope_dy; b = it.slope_dx; c = it.point_y;
		end
		n    = (c - longint'(it.tube_coord)) * dz
			+ a * (longint'(it.tube_z) - longint'(it.point_z));
		an   = (n < 0) ? longint'(-n) : n;
		q    = a * a + dz * dz;
		q3   = q + b * b;
		s    = int_sqrt(q << 16);
		axis_d = (an << 8) / s;
		if (axis_d > 64'hFFFF_FFFF)
			axis_d = 64'hFFFF_FFFF;
		rr  = rad;
		len = 0;
		if (axis_d < rr) begin
			res.crosses_tube = 1'b1;
			m   = rr * rr - axis_d * axis_d;
			w   = int_sqrt(m << 16);
			g   = int_sqrt((q3 << 24) / q);
			len = (2 * w * g) >> 20;
			if (len > 64'hFFFF_FFFF)
				len = 64'hFFFF_FFFF;
		end
		res.axis_distance = axis_d[31:0];
		res.path_length   = len[31:0];
		return res;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// record each track transfer, check each result transfer
	always @(posedge clk) begin
		chord_t want;
		chord_t got;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				got = {result_ch.axis_distance, result_ch.path_length,
					result_ch.crosses_tube, result_ch.slope_error};
				if (chord_q.size() == 0) begin
					n_fail++;
					$display("%0t: unexpected result %h", $time, got);
				end else begin
					want = chord_q.pop_front();
					if (got.axis_distance !== want.axis_distance) begin
						n_fail++;
						$display("%0t: axis_distance expected %h actual %h", $time,
							want.axis_distance, got.axis_distance);
					end
					if (got.path_length !== want.path_length) begin
						n_fail++;
						$display("%0t: path_length expected %h actual %h", $time,
							want.path_length, got.path_length);
					end
					if (got.crosses_tube !== want.crosses_tube) begin
						n_fail++;
						$display("%0t: crosses_tube expected %b actual %b", $time,
							want.crosses_tube, got.crosses_tube);
					end
					if (got.slope_error !== want.slope_error) begin
						n_fail++;
						$display("%0t: slope_error expected %b actual %b", $time,
							want.slope_error, got.slope_error);
					end
				end
			end
			if (track_ch.valid && track_ch.ready)
				chord_q.push_back(chord_of({track_ch.point_x, track_ch.point_y,
					track_ch.point_z, track_ch.slope_dx, track_ch.slope_dy,
					track_ch.slope_dz, track_ch.tube_axis, track_ch.tube_z,
					track_ch.tube_coord}, radius_now));
		end
	end

	// receiver: long hold on request, otherwise a changing stall pattern
	initial begin
		int mode;
		int left;
		int held;
		result_ch.ready <= 1'b0;
		mode = 0;
		left = 0;
		held = 0;
		forever begin
			@(posedge clk);
			if (hold_req && held == 0) begin
				held     = HOLD_LEN;
				hold_req = 1'b0;
			end
			if (held > 0) begin
				held--;
				result_ch.ready <= 1'b0;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(8, 80);
				end
				left--;
				case (mode)
					0: begin
						result_ch.ready <= 1'b1;
					end
					1: begin
						result_ch.ready <= $urandom_range(0, 1);
					end
					2: begin
						result_ch.ready <= ($urandom_range(0, 3) == 0);
					end
					default: begin
						result_ch.ready <= ($urandom_range(0, 7) != 0);
					end
				endcase
			end
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((track_ch.valid && track_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// offer one track and hold it until transferred; valid stays high
	task automatic send_track(input item_t it);
		track_ch.valid      <= 1'b1;
		track_ch.point_x    <= it.point_x;
		track_ch.point_y    <= it.point_y;
		track_ch.point_z    <= it.point_z;
		track_ch.slope_dx   <= it.slope_dx;
		track_ch.slope_dy   <= it.slope_dy;
		track_ch.slope_dz   <= it.slope_dz;
		track_ch.tube_axis  <= it.tube_axis;
		track_ch.tube_z     <= it.tube_z;
		track_ch.tube_coord <= it.tube_coord;
		do @(posedge clk); while (!track_ch.ready);
	endtask

	task automatic pause_track(input int cycles);
		track_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// drain, let the pipeline settle, then write the radius
	task automatic write_radius(input logic [RADIUS_W-1:0] val);
		pause_track(1);
		wait (chord_q.size() == 0);
		repeat (LATENCY + 8) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		radius_now = val;
	endtask

	function automatic logic signed [SLOPE_W-1:0] rand_slope();
		return SLOPE_W'(int'($urandom_range(0, 131072)) - 65536);
	endfunction

	// track aimed close to the tube, or anything at all
	function automatic item_t make_track(input bit aimed);
		item_t it;
		int    spread;
		it.point_x   = $urandom;
		it.point_y   = $urandom;
		it.point_z   = $urandom;
		it.slope_dx  = rand_slope();
		it.slope_dy  = rand_slope();
		it.slope_dz  = rand_slope();
		it.tube_axis = $urandom_range(0, 1);
		it.tube_z    = $urandom;
		it.tube_coord = $urandom;
		if (aimed) begin
			spread = 2 * int'(radius_now) + 16;
			it.tube_z     = int'($urandom_range(0, 2000000)) - 1000000;
			it.tube_coord = int'($urandom_range(0, 2000000)) - 1000000;
			it.point_z    = it.tube_z + int'($urandom_range(0, 2 * spread)) - spread;
			if (it.tube_axis)
				it.point_y = it.tube_coord + int'($urandom_range(0, 2 * spread)) - spread;
			else
				it.point_x = it.tube_coord + int'($urandom_range(0, 2 * spread)) - spread;
			if ($urandom_range(0, 3) != 0)
				it.slope_dz = SLOPE_W'(int'($urandom_range(20000, 65536))
					* ($urandom_range(0, 1) ? 1 : -1));
		end
		return it;
	endfunction

	task automatic send_burst(input int count, input bit pressure);
		int k;
		int burst;
		k = 0;
		while (k < count) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && k < count) begin
				send_track(make_track($urandom_range(0, 4) != 0));
				burst--;
				k++;
			end
			if (!pressure && $urandom_range(0, 2) != 0)
				pause_track($urandom_range(1, 12));
		end
	endtask

	task automatic test_directed();
		item_t it;
		int    k;
		for (k = 0; k < 20; k++) begin
			it = '0;
			it.tube_axis = k[0];
			it.slope_dz  = 18'sd65536;
			case (k / 2)
				0: begin
					// zero dz on either axis
					it.slope_dz = '0;
					it.slope_dx = 18'sd65536;
				end
				1: begin
					// straight down through the axis
				end
				2: begin
					// just inside the radius
					it.point_x = radius_now - 1;
					it.point_y = radius_now - 1;
				end
				3: begin
					// exactly at the radius
					it.point_x = radius_now;
					it.point_y = radius_now;
				end
				4: begin
					// coordinate extremes, distance just below saturation
					it.point_x    = 32'sh7FFF_FFFF;
					it.point_y    = 32'sh7FFF_FFFF;
					it.tube_coord = 32'sh8000_0000;
					it.point_z    = 32'sh8000_0000;
					it.tube_z     = 32'sh7FFF_FFFF;
					it.slope_dx   = -18'sd65536;
					it.slope_dy   = -18'sd65536;
					it.slope_dz   = 18'sd1;
				end
				5: begin
					// steep track, long chord
					it.slope_dx = 18'sd65536;
					it.slope_dy = 18'sd65536;
					it.slope_dz = 18'sd1;
				end
				6: begin
					// unnormalized direction, all components of magnitude 65536
					it.slope_dx = 18'sd65536;
					it.slope_dy = -18'sd65536;
					it.slope_dz = -18'sd65536;
					it.point_z  = 32'sd1000;
				end
				7: begin
					// all coordinates at the negative extreme, all slopes at -65536
					it.point_x    = 32'sh8000_0000;
					it.point_y    = 32'sh8000_0000;
					it.point_z    = 32'sh8000_0000;
					it.tube_z     = 32'sh8000_0000;
					it.tube_coord = 32'sh8000_0000;
					it.slope_dx   = -18'sd65536;
					it.slope_dy   = -18'sd65536;
					it.slope_dz   = -18'sd65536;
				end
				8: begin
					it.slope_dx = 18'sd100;
					it.slope_dz = -18'sd3;
					it.point_x  = 32'sd50;
					it.point_y  = -32'sd50;
				end
				default: begin
					it.point_x    = 32'sh7FFF_FFFF;
					it.point_y    = 32'sh7FFF_FFFF;
					it.point_z    = 32'sh7FFF_FFFF;
					it.tube_z     = 32'sh7FFF_FFFF;
					it.tube_coord = 32'sh7FFF_FFFF;
					it.slope_dx   = 18'sd65535;
					it.slope_dy   = 18'sd65535;
					it.slope_dz   = 18'sd65535;
				end
			endcase
			send_track(it);
		end
		pause_track(1);
	endtask

	task automatic test_radius_settings();
		write_radius(20'hFFFFF);
		send_burst(120, 1'b0);
		write_radius(20'd1);
		send_burst(60, 1'b0);
		write_radius(20'($urandom_range(1, 1048575)));
		send_burst(120, 1'b0);
		write_radius(RADIUS_RESET);
	endtask

	task automatic test_random_tracks();
		send_burst(200, 1'b0);
	endtask

	task automatic test_backpressure();
		@(posedge clk);
		hold_req = 1'b1;
		send_burst(180, 1'b1);
		pause_track(1);
	endtask

	initial begin
		n_fail       = 0;
		hold_req     = 1'b0;
		quiet_cycles = 0;
		radius_now   = RADIUS_RESET;
		arst_n       = 1'b0;
		track_ch.valid      = 1'b0;
		track_ch.point_x    = '0;
		track_ch.point_y    = '0;
		track_ch.point_z    = '0;
		track_ch.slope_dx   = '0;
		track_ch.slope_dy   = '0;
		track_ch.slope_dz   = '0;
		track_ch.tube_axis  = 1'b0;
		track_ch.tube_z     = '0;
		track_ch.tube_coord = '0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.data         = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_tracks();
		test_backpressure();
		test_radius_settings();

		// drain and let the pipeline settle
		wait (chord_q.size() == 0);
		repeat (LATENCY + 8) @(posedge clk);
		if (n_fail == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* filelist.f */
hdl/ttpl_pkg.sv
hdl/ttpl_ifs.sv
hdl/ttpl_front.sv
hdl/ttpl_isqrt.sv
hdl/ttpl_div.sv
hdl/tube_track_path_length.sv
tb/sv/testbench.sv
